>>> rtl/ffca_pkg.sv
// Package for the first-fit capacity allocator.
// Holds default sizes, field widths, action codes and the controller state type.
// No dependencies.
package ffca_pkg;

   localparam int ENTRIES_DEF    = 1024;
   localparam int VALUE_BITS_DEF = 32;
   localparam int SLOT_BITS      = 11;
   localparam int AMOUNT_BITS    = 32;

   localparam logic [SLOT_BITS-1:0] ACTIVE_RESET = 11'd1024;

   localparam logic ACTION_LOAD    = 1'b0;
   localparam logic ACTION_REQUEST = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_DESC,
      ST_FIT,
      ST_LEAF_WR,
      ST_UP
   } state_type;

endpackage

>>> rtl/first_fit_capacity_allocator_unit.sv
// First-fit capacity allocator: max tree over slot capacities in one node RAM.
// A granted request strobes rsp_valid with its slot, then writes the reduced leaf and walks
// up the tree; a miss at the root or past the active count strobes with slot 0. A load writes
// its leaf and walks up; a load to slot 0 or past ENTRIES is ignored. One request at a time;
// the strobe cannot be held off. Synchronous reset starts a clearing pass over every node with
// busy high. Depends on ffca_pkg and ffca_node_ram.
module first_fit_capacity_allocator_unit import ffca_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_action,
   input  logic [SLOT_BITS-1:0]   req_slot_index,
   input  logic [AMOUNT_BITS-1:0] req_amount,
   output logic                   rsp_valid,
   output logic [SLOT_BITS-1:0]   rsp_granted_slot,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SLOT_BITS-1:0]   csr_active_count
);

   localparam int LEVELS = $clog2(ENTRIES);
   localparam int NODE_W = LEVELS + 1;
   localparam int DEPTH  = 2 << LEVELS;
   localparam int CMP_W  = (SLOT_BITS > NODE_W) ? SLOT_BITS : NODE_W;

   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
   localparam logic [CMP_W-1:0]  ENTRIES_C = CMP_W'(ENTRIES);

   state_type state_ff, state_in;

   logic [SLOT_BITS-1:0]  active_ff;
   logic [NODE_W-1:0]     clr_ff;
   logic [NODE_W-1:0]     node_ff, node_in;
   logic [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [VALUE_BITS-1:0] amt_ff, amt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0]  rsp_slot_ff, rsp_slot_in;

   logic                  wr_en, rd_en;
   logic [NODE_W-1:0]     wr_addr, rd_addr;
   logic [VALUE_BITS-1:0] wr_data, rd_data;

   logic [CMP_W-1:0]      req_slot_c, req_slot_m1, found_c;
   logic                  load_ok, data_ge, fit;
   logic [NODE_W-1:0]     load_leaf, child, parent;
   logic [VALUE_BITS-1:0] up_max;

   ffca_node_ram #(
      .DEPTH (DEPTH),
      .WIDTH (VALUE_BITS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_slot_c  = CMP_W'(req_slot_index);
   assign req_slot_m1 = req_slot_c - CMP_W'(1);
   assign load_ok     = (req_slot_c != '0) && (req_slot_c <= ENTRIES_C);
   assign load_leaf   = {1'b1, req_slot_m1[LEVELS-1:0]};

   assign data_ge = rd_data >= amt_ff;
   assign child   = data_ge ? {node_ff[NODE_W-2:0], 1'b0} : {node_ff[NODE_W-2:0], 1'b1};
   assign parent  = node_ff >> 1;
   assign up_max  = (rd_data > cur_ff) ? rd_data : cur_ff;

   assign found_c = CMP_W'({1'b0, node_ff[LEVELS-1:0]}) + CMP_W'(1);
   assign fit     = (found_c <= CMP_W'(active_ff)) && (found_c <= ENTRIES_C);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACTION_REQUEST) state_in = ST_ROOT;
               else if (load_ok)                 state_in = ST_LEAF_WR;
            end
         end
         ST_ROOT: begin
            state_in = data_ge ? ST_DESC : ST_IDLE;
         end
         ST_DESC: begin
            if (child[LEVELS]) state_in = ST_FIT;
         end
         ST_FIT: begin
            state_in = fit ? ST_LEAF_WR : ST_IDLE;
         end
         ST_LEAF_WR: begin
            state_in = ST_UP;
         end
         ST_UP: begin
            if (parent == ROOT_NODE) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      node_in = node_ff;
      cur_in  = cur_ff;
      amt_in  = amt_ff;
      case (state_ff)
         ST_IDLE: begin
            amt_in  = VALUE_BITS'(req_amount);
            node_in = load_leaf;
            cur_in  = VALUE_BITS'(req_amount);
         end
         ST_ROOT: begin
            node_in = ROOT_NODE;
            cur_in  = rd_data;
         end
         ST_DESC: begin
            node_in = child;
            if (data_ge) cur_in = rd_data;
         end
         ST_FIT: begin
            cur_in = cur_ff - amt_ff;
         end
         ST_UP: begin
            node_in = parent;
            cur_in  = up_max;
         end
         default: begin
            node_in = node_ff;
         end
      endcase
   end

   // outputs: RAM control and result
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = ROOT_NODE;
      rsp_valid_in = 1'b0;
      rsp_slot_in  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            rd_en = start && (req_action == ACTION_REQUEST);
         end
         ST_ROOT: begin
            rd_en        = data_ge;
            rd_addr      = {ROOT_NODE[NODE_W-2:0], 1'b0};
            rsp_valid_in = !data_ge;
         end
         ST_DESC: begin
            rd_en   = !child[LEVELS];
            rd_addr = {child[NODE_W-2:0], 1'b0};
         end
         ST_FIT: begin
            rsp_valid_in = 1'b1;
            rsp_slot_in  = fit ? SLOT_BITS'(found_c) : '0;
         end
         ST_LEAF_WR: begin
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = node_ff ^ NODE_W'(1);
         end
         ST_UP: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = up_max;
            rd_en   = parent != ROOT_NODE;
            rd_addr = parent ^ NODE_W'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + NODE_W'(1);
         if (csr_valid && csr_ready) active_ff <= csr_active_count;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      cur_ff      <= cur_in;
      amt_ff      <= amt_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;

endmodule

>>> rtl/ffca_node_ram.sv
// Node store of the max tree: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
module ffca_node_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
